>>> rtl/psq_pkg.sv
`default_nettype none
package psq_pkg;
  localparam int DEPTH = 32;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_SENT = 2'd1,
    OP_FAIL = 2'd2,
    OP_QRY  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NF   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] event_id;
    logic [7:0]  priority_req;
    logic [47:0] enqueue_time;
    logic [47:0] now_ms;
    logic        start_sending;
    logic        start_failed;
    logic [7:0]  start_retries;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        next_valid;
    logic [15:0] next_event_id;
    logic [7:0]  next_priority;
    logic [7:0]  next_retries;
    logic [5:0]  total_count;
    logic [5:0]  pending_count;
    logic [5:0]  sending_count;
    logic [5:0]  failed_count;
    logic [47:0] oldest_time;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [47:0] time_ms;
    logic        sending;
    logic        failed;
    logic [7:0]  retries;
  } entry_t;

  // Scan token passed cell to cell: running statistics and best pick.
  typedef struct packed {
    logic        have_best;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [7:0]  retries;
    logic [CW-1:0] total;
    logic [CW-1:0] pend;
    logic [CW-1:0] snd;
    logic [CW-1:0] fail;
    logic        have_old;
    logic [47:0] oldest;
  } scan_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic        enq;      // write new entry into first empty cell
    logic        sent;     // drop entries matching id, compact
    logic        fail;     // fail first matching entry
    logic [15:0] id;
    entry_t      new_ent;
  } cmd_t;
endpackage
`default_nettype wire

>>> rtl/psq_cell.sv
`default_nettype none
module psq_cell
  import psq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cmd_t   cmd,
  input  wire logic   prev_valid,   // left neighbor holds an entry
  input  wire logic   left_hit,     // a match exists at or left of prev cell
  input  wire logic   left_drop_any,// shift-in needed: some cell at/left dropped
  input  wire entry_t right_ent,    // right neighbor's entry
  input  wire logic   right_drop_cnt_ok, // high where a right neighbor exists; low empties the shifted-in entry
  input  wire scan_t  scan_in,
  output scan_t       scan_out,
  output entry_t      ent,
  output logic        hit_out,      // match here or to the left
  output logic        drop_out      // some drop here or to the left
);
  entry_t ent_r, ent_nxt;
  logic   match;
  logic   act;

  assign ent   = ent_r;
  assign match = ent_r.valid && (ent_r.id == cmd.id);
  assign hit_out  = left_hit || match;
  assign drop_out = left_drop_any || (cmd.sent && match);

  // Mark-sent compaction is done one removal per cycle by the control;
  // a cell shifts the right neighbor in when a drop happened at or left.
  always_comb begin
    ent_nxt = ent_r;
    act = 1'b0;
    if (cmd.enq) begin
      if (!ent_r.valid && prev_valid) ent_nxt = cmd.new_ent;
    end else if (cmd.sent) begin
      if (drop_out) begin
        ent_nxt = right_ent;
        if (!right_drop_cnt_ok) ent_nxt.valid = 1'b0;
      end
    end else if (cmd.fail) begin
      act = match && !left_hit;
      if (act) begin
        ent_nxt.failed  = 1'b1;
        ent_nxt.sending = 1'b0;
        if (ent_r.retries != 8'hFF) ent_nxt.retries = ent_r.retries + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  // Statistics hop: registered token toward the tail.
  scan_t s;
  always_comb begin
    s = scan_in;
    if (ent_r.valid) begin
      s.total = scan_in.total + CW'(1);
      if (ent_r.sending) s.snd = scan_in.snd + CW'(1);
      else if (ent_r.failed) s.fail = scan_in.fail + CW'(1);
      else begin
        s.pend = scan_in.pend + CW'(1);
        if (!scan_in.have_best || ent_r.prio < scan_in.prio) begin
          s.have_best = 1'b1;
          s.id = ent_r.id;
          s.prio = ent_r.prio;
          s.retries = ent_r.retries;
        end
      end
      if (!scan_in.have_old || ent_r.time_ms < scan_in.oldest) begin
        s.have_old = 1'b1;
        s.oldest = ent_r.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= s;
  end
endmodule
`default_nettype wire

>>> rtl/priority_send_queue_unit.sv
`default_nettype none
// Priority send queue: a row of DEPTH cells holding entries contiguously in
// insertion order. Enqueue and mark-failed are applied in the update state.
// Mark-sent removes one matching entry per cycle (each removal shifts the
// tail left by one cell) and stays in the update state until no match is
// left. After the update, a statistics token walks the row one cell per
// cycle and the result register loads once it has passed the whole row.
// The input is taken again only once the result item has left.
module priority_send_queue_unit
  import psq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);
  typedef enum logic [1:0] {S_IDLE, S_UPD, S_SCAN, S_OUT} state_t;
  localparam int SW = $clog2(DEPTH + 2);

  state_t   state_r;
  in_item_t item_r;
  logic [1:0] status_r;
  logic [SW-1:0] cnt_r;
  logic     found_r;
  out_item_t out_r;

  cmd_t   cmd;
  entry_t ents [DEPTH];
  scan_t  scans [DEPTH+1];
  logic   hits  [DEPTH+1];
  logic   drops [DEPTH+1];
  logic   first_drop [DEPTH];

  assign hits[0]  = 1'b0;
  assign drops[0] = 1'b0;
  assign scans[0] = '0;

  always_comb begin
    cmd = '0;
    cmd.id = item_r.event_id;
    cmd.new_ent.valid   = 1'b1;
    cmd.new_ent.id      = item_r.event_id;
    cmd.new_ent.prio    = item_r.priority_req;
    cmd.new_ent.time_ms = (item_r.enqueue_time != 48'd0) ? item_r.enqueue_time
                                                         : item_r.now_ms;
    cmd.new_ent.sending = item_r.start_sending;
    cmd.new_ent.failed  = item_r.start_failed;
    cmd.new_ent.retries = item_r.start_retries;
    if (state_r == S_UPD) begin
      unique case (op_t'(item_r.operation))
        OP_ENQ:  cmd.enq  = 1'b1;
        OP_SENT: cmd.sent = 1'b1;
        OP_FAIL: cmd.fail = 1'b1;
        default: ;
      endcase
    end
  end

  // Drop chain: only the first matching cell drops per cycle.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t rn;
    assign rn = (g == DEPTH - 1) ? entry_t'('0) : ents[(g + 1) % DEPTH];
    psq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .prev_valid((g == 0) ? 1'b1 : ents[(g + DEPTH - 1) % DEPTH].valid),
      .left_hit(hits[g]),
      .left_drop_any(drops[g]),
      .right_ent(rn),
      .right_drop_cnt_ok(g != DEPTH - 1),
      .scan_in(scans[g]), .scan_out(scans[g+1]),
      .ent(ents[g]), .hit_out(hits[g+1]), .drop_out(first_drop[g])
    );
    // A drop only propagates from the first match, so removal is one per cycle.
    assign drops[g+1] = first_drop[g] && !(hits[g] && !drops[g]) ;
  end

  logic full;
  assign full = ents[DEPTH-1].valid;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          item_r  <= in_data;
          state_r <= S_UPD;
          found_r <= 1'b0;
          status_r <= (op_t'(in_data.operation) == OP_ENQ && full) ? ST_FULL : ST_OK;
        end
        S_UPD: begin
          if (op_t'(item_r.operation) == OP_SENT && hits[DEPTH]) begin
            found_r <= 1'b1;            // one removal done, try again
          end else begin
            if (op_t'(item_r.operation) == OP_SENT && !found_r) status_r <= ST_NF;
            if (op_t'(item_r.operation) == OP_FAIL && !hits[DEPTH])
              status_r <= ST_NF;
            cnt_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + SW'(1);
          if (cnt_r == SW'(DEPTH)) begin
            out_r.status        <= status_r;
            out_r.next_valid    <= scans[DEPTH].have_best;
            out_r.next_event_id <= scans[DEPTH].have_best ? scans[DEPTH].id : 16'd0;
            out_r.next_priority <= scans[DEPTH].have_best ? scans[DEPTH].prio : 8'd0;
            out_r.next_retries  <= scans[DEPTH].have_best ? scans[DEPTH].retries : 8'd0;
            out_r.total_count   <= CNT_W'(scans[DEPTH].total);
            out_r.pending_count <= CNT_W'(scans[DEPTH].pend);
            out_r.sending_count <= CNT_W'(scans[DEPTH].snd);
            out_r.failed_count  <= CNT_W'(scans[DEPTH].fail);
            out_r.oldest_time   <= scans[DEPTH].have_old ? scans[DEPTH].oldest : 48'd0;
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/psq_checker.sv
`default_nettype none
module psq_checker
  import psq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken too early");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.total_count ==
      out_data.pending_count + out_data.sending_count + out_data.failed_count)
    else $error("counts disagree");
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.next_valid == (out_data.pending_count != 6'd0)))
    else $error("next_valid disagrees with pending count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
endmodule

bind priority_send_queue_unit psq_checker u_psq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

>>> tb/tb_priority_send_queue_unit.sv
`default_nettype none
module tb_priority_send_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import psq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  priority_send_queue_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow of the table: entries kept packed at 0..held-1 in insertion order.
  entry_t    table_q[$];
  out_item_t expected_q[$];
  int        fail_count;
  int        items_sent;
  int        results_seen;
  int        full_drops;
  int        not_found_hits;
  bit        hold_off;      // long receiver stall requested by a test
  int        hold_cycles;
  int        fill_gap;      // 1: sender offers back to back

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow table and predict the result item.
  function automatic out_item_t queue_update(in_item_t it);
    out_item_t r;
    entry_t    e;
    int        best;
    bit        found;
    logic [47:0] oldest;
    r = '0;
    r.status = ST_OK;
    case (op_t'(it.operation))
      OP_ENQ: begin
        if (table_q.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.valid   = 1'b1;
          e.id      = it.event_id;
          e.prio    = it.priority_req;
          e.time_ms = (it.enqueue_time != 0) ? it.enqueue_time : it.now_ms;
          e.sending = it.start_sending;
          e.failed  = it.start_failed;
          e.retries = it.start_retries;
          table_q = {table_q, e};
        end
      end
      OP_SENT: begin
        found = 1'b0;
        for (int i = table_q.size() - 1; i >= 0; i--) begin
          if (table_q[i].id == it.event_id) begin
            table_q.delete(i);
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_NF;
      end
      OP_FAIL: begin
        r.status = ST_NF;
        foreach (table_q[i]) begin
          if (table_q[i].id == it.event_id) begin
            table_q[i].failed  = 1'b1;
            table_q[i].sending = 1'b0;
            if (table_q[i].retries != 8'hFF) table_q[i].retries++;
            r.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    // Statistics and selection; strict less-than keeps the earliest on ties.
    best = -1;
    oldest = '0;
    foreach (table_q[i]) begin
      if (table_q[i].sending) r.sending_count++;
      else if (table_q[i].failed) r.failed_count++;
      else begin
        r.pending_count++;
        if (best < 0 || table_q[i].prio < table_q[best].prio) best = i;
      end
      if (i == 0 || table_q[i].time_ms < oldest) oldest = table_q[i].time_ms;
    end
    r.total_count = 6'(table_q.size());
    r.oldest_time = oldest;
    if (best >= 0) begin
      r.next_valid    = 1'b1;
      r.next_event_id = table_q[best].id;
      r.next_priority = table_q[best].prio;
      r.next_retries  = table_q[best].retries;
    end
    return r;
  endfunction

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one item; prediction is made at acceptance. Valid stays up after
  // acceptance only when the next item follows in the same step.
  task automatic send_item(in_item_t it);
    int g;
    g = (fill_gap != 0) ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q = {expected_q, queue_update(it)};
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t make_item(op_t op, logic [15:0] id, logic [7:0] prio,
                                         logic [47:0] et, logic [47:0] now,
                                         logic snd, logic fl, logic [7:0] rt);
    in_item_t it;
    it.operation     = op;
    it.event_id      = id;
    it.priority_req  = prio;
    it.enqueue_time  = et;
    it.now_ms        = now;
    it.start_sending = snd;
    it.start_failed  = fl;
    it.start_retries = rt;
    return it;
  endfunction

  // Random item; ids from a small pool most of the time so ops find matches.
  function automatic in_item_t rand_item(int enq_weight);
    in_item_t it;
    logic [159:0] raw;
    int p;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    p = $urandom_range(0, 99);
    if (p < enq_weight) it.operation = OP_ENQ;
    else if (p < enq_weight + (100 - enq_weight) / 3) it.operation = OP_SENT;
    else if (p < enq_weight + 2 * (100 - enq_weight) / 3) it.operation = OP_FAIL;
    else it.operation = OP_QRY;
    if ($urandom_range(0, 9) < 8) it.event_id = 16'($urandom_range(0, 11));
    if ($urandom_range(0, 3) == 0) it.enqueue_time = '0;
    if ($urandom_range(0, 7) == 0) it.now_ms = '0;
    if ($urandom_range(0, 3) != 0) it.start_sending = 1'b0;
    if ($urandom_range(0, 3) != 0) it.start_failed = 1'b0;
    if ($urandom_range(0, 7) == 0) it.start_retries = 8'hFE + 8'($urandom_range(0, 1));
    return it;
  endfunction

  // Result side: random stalls plus an optional long hold-off.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_off = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker: compare each accepted item with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        out_item_t x;
        x = expected_q.pop_front();
        if (x.status == ST_FULL) full_drops++;
        if (x.status == ST_NF) not_found_hits++;
        if (out_data.status !== x.status) begin
          $error("status exp %0d got %0d", x.status, out_data.status); fail_count++;
        end
        if (out_data.next_valid !== x.next_valid) begin
          $error("next_valid exp %0d got %0d", x.next_valid, out_data.next_valid);
          fail_count++;
        end
        if (out_data.next_event_id !== x.next_event_id) begin
          $error("next_event_id exp %0h got %0h", x.next_event_id, out_data.next_event_id);
          fail_count++;
        end
        if (out_data.next_priority !== x.next_priority) begin
          $error("next_priority exp %0d got %0d", x.next_priority, out_data.next_priority);
          fail_count++;
        end
        if (out_data.next_retries !== x.next_retries) begin
          $error("next_retries exp %0d got %0d", x.next_retries, out_data.next_retries);
          fail_count++;
        end
        if (out_data.total_count !== x.total_count) begin
          $error("total_count exp %0d got %0d", x.total_count, out_data.total_count);
          fail_count++;
        end
        if (out_data.pending_count !== x.pending_count) begin
          $error("pending_count exp %0d got %0d", x.pending_count, out_data.pending_count);
          fail_count++;
        end
        if (out_data.sending_count !== x.sending_count) begin
          $error("sending_count exp %0d got %0d", x.sending_count, out_data.sending_count);
          fail_count++;
        end
        if (out_data.failed_count !== x.failed_count) begin
          $error("failed_count exp %0d got %0d", x.failed_count, out_data.failed_count);
          fail_count++;
        end
        if (out_data.oldest_time !== x.oldest_time) begin
          $error("oldest_time exp %0h got %0h", x.oldest_time, out_data.oldest_time);
          fail_count++;
        end
      end
    end
  end

  // Directed: empty-table ops, field extremes, ties, both flags, zero times.
  task automatic test_directed();
    send_item(make_item(OP_QRY, 16'h0, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0));
    send_item(make_item(OP_SENT, 16'h5, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0));   // not found
    send_item(make_item(OP_FAIL, 16'h5, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0));   // not found
    send_item(make_item(OP_ENQ, 16'hFFFF, 8'hFF, {48{1'b1}}, '0, 1'b0, 1'b0, 8'hFF));
    send_item(make_item(OP_ENQ, 16'h0001, 8'h10, '0, 48'h1234, 1'b0, 1'b0, 8'h00));
    send_item(make_item(OP_ENQ, 16'h0002, 8'h10, 48'h5, 48'h9, 1'b0, 1'b0, 8'h07)); // tie
    send_item(make_item(OP_ENQ, 16'h0003, 8'h00, '0, '0, 1'b1, 1'b1, 8'h01)); // zero time
    send_item(make_item(OP_ENQ, 16'h0004, 8'h00, 48'h7, '0, 1'b1, 1'b0, 8'h02));
    send_item(make_item(OP_ENQ, 16'h0005, 8'h00, 48'h8, '0, 1'b0, 1'b1, 8'h03));
    send_item(make_item(OP_FAIL, 16'hFFFF, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0)); // saturate
    send_item(make_item(OP_FAIL, 16'hFFFF, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0));
    send_item(make_item(OP_ENQ, 16'h0001, 8'h01, 48'h3, '0, 1'b0, 1'b0, 8'hFE));
    send_item(make_item(OP_FAIL, 16'h0001, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0)); // first only
    send_item(make_item(OP_FAIL, 16'h0003, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0)); // clears sending
    send_item(make_item(OP_SENT, 16'h0001, 8'h0, '0, '0, 1'b0, 1'b0, 8'h0)); // removes both
    send_item(make_item(OP_QRY, 16'hFFFF, 8'hFF, {48{1'b1}}, {48{1'b1}}, 1'b1, 1'b1, 8'hFF));
    wait_drained();
    // Flush so the next test starts empty.
    for (int i = 0; i < 6; i++)
      send_item(make_item(OP_SENT, 16'(i == 0 ? 16'hFFFF : i + 1), 8'h0, '0, '0,
                          1'b0, 1'b0, 8'h0));
  endtask

  // Fill past DEPTH with a long receiver hold-off so the block stalls.
  task automatic test_full_table();
    in_item_t it;
    hold_off = 1'b1;
    fill_gap = 1;
    for (int i = 0; i < DEPTH + 4; i++) begin
      it = rand_item(100);
      send_item(it);
    end
    fill_gap = 0;
    wait_drained();       // sender pauses until everything is back
    for (int i = 0; i < 20; i++) send_item(rand_item(10));
  endtask

  // Random mix; enqueue weight drifts so the table swings between empty and full.
  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++)
      send_item(rand_item(((i / 200) % 2 == 0) ? 60 : 30));
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (3 * DEPTH + 20) @(posedge clk);
    $display("covered %0d items, %0d results: %0d dropped on full table, %0d id misses",
             items_sent, results_seen, full_drops, not_found_hits);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb_priority_send_queue_unit OK");
    end else begin
      $display("tb_priority_send_queue_unit NOT OK");
    end
    $finish;
  endtask

  initial begin
    fail_count = 0; items_sent = 0; results_seen = 0;
    full_drops = 0; not_found_hits = 0;
    hold_off = 1'b0; fill_gap = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random_mix(1500);
    finish_run();
  end

  // Worst case ~1600 items, each with block time, gap and stall, plus hold-off.
  initial begin
    #10ms;
    $display("tb_priority_send_queue_unit NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
